FILE: rtl/pic_pkg.sv
// Shared types and constants for the mid-range instruction execute unit.
`timescale 1ns / 1ps
package pic_pkg;
  localparam int StackDepthDef = 8;
  localparam int RamWordsDef   = 128;
  localparam int PcBitsDef     = 13;
  localparam int InstrBits     = 14;
  localparam int FileAddrBits  = 7;

  // Status bits that travel with each result word.
  typedef struct packed {
    logic       zero;
    logic       dcarry;
    logic       carry;
    logic [1:0] cycles;
    logic       not_done;
    logic       bad;
  } pic_status_t;
endpackage

FILE: rtl/pic_file_ram.sv
// File RAM: one synchronous write port, one registered read port.
`timescale 1ns / 1ps
module pic_file_ram #(
  parameter int RAM_WORDS = pic_pkg::RamWordsDef
) (
  input  logic                            clk,
  input  logic [pic_pkg::FileAddrBits-1:0] rd_addr,
  output logic [7:0]                       rd_data,
  input  logic                            wr_en,
  input  logic [pic_pkg::FileAddrBits-1:0] wr_addr,
  input  logic [7:0]                       wr_data
);
  import pic_pkg::*;
  localparam int AW = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;

  logic [7:0] mem [RAM_WORDS];

  // Write only in range; read registered.
  always_ff @(posedge clk) begin
    if (wr_en && ({1'b0, wr_addr} < (FileAddrBits+1)'(RAM_WORDS))) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
    rd_data <= mem[rd_addr[AW-1:0]];
  end
endmodule

FILE: rtl/pic_core.sv
// Decode and execute: read, modify, write-back sequencer.
`timescale 1ns / 1ps
module pic_core #(
  parameter int STACK_DEPTH = pic_pkg::StackDepthDef,
  parameter int RAM_WORDS   = pic_pkg::RamWordsDef,
  parameter int PC_BITS     = pic_pkg::PcBitsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [pic_pkg::InstrBits-1:0] in_word,
  output logic                          in_stall,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [PC_BITS-1:0]            res_pc,
  output logic [7:0]                    res_w,
  output pic_pkg::pic_status_t          res_status
);
  import pic_pkg::*;
  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Execute phase holds the fetched word while RAM data arrives.
  logic                  ex_busy;
  logic [InstrBits-1:0]  ex_word;
  logic [7:0]            w_reg;
  logic                  c_reg, dc_reg, z_reg;
  logic [PC_BITS-1:0]    pc;
  logic [SW-1:0]         sp;
  logic [PC_BITS-1:0]    stack_mem [STACK_DEPTH];

  logic [6:0] rd_addr;
  logic [7:0] rd_data;
  logic       wr_en;
  logic [7:0] wr_data;
  logic       out_free;
  logic       take;
  logic       retire;

  assign out_free = !res_valid || !res_stall;
  assign in_stall = ex_busy;
  assign take     = in_valid && !ex_busy;
  assign retire   = ex_busy && out_free;

  // Keep re-reading the held word's operand while it waits on the output.
  assign rd_addr  = ex_busy ? ex_word[6:0] : in_word[6:0];

  pic_file_ram #(.RAM_WORDS(RAM_WORDS)) u_ram (
    .clk(clk), .rd_addr(rd_addr), .rd_data(rd_data),
    .wr_en(wr_en), .wr_addr(ex_word[6:0]), .wr_data(wr_data)
  );

  // Combinational execute of the held word.
  logic [6:0]         f;
  logic               dbit;
  logic [7:0]         k8, fv, r, bmask;
  logic [8:0]         sum;
  logic [PC_BITS-1:0] pc1, pc2, pc_n, stk_top;
  logic [SW-1:0]      sp_dn, sp_n;
  logic               push;
  logic [7:0]         w_n;
  logic               c_n, dc_n, z_n, nd, bad;
  logic [1:0]         cyc;
  logic               in_range;

  always_comb begin
    f        = ex_word[6:0];
    dbit     = ex_word[7];
    k8       = ex_word[7:0];
    in_range = ({1'b0, f} < 8'(RAM_WORDS));
    fv       = in_range ? rd_data : 8'h00;
    bmask    = 8'h01 << ex_word[9:7];
    pc1      = pc + 1'b1;
    pc2      = pc + PC_BITS'(2);
    sp_dn    = (sp == '0) ? SW'(STACK_DEPTH - 1) : sp - 1'b1;
    stk_top  = stack_mem[sp_dn];
    pc_n = pc1; sp_n = sp; push = 1'b0;
    w_n = w_reg; c_n = c_reg; dc_n = dc_reg; z_n = z_reg;
    nd = 1'b0; bad = 1'b0; cyc = 2'd1;
    wr_en = 1'b0; r = 8'h00; wr_data = 8'h00; sum = 9'h000;
    unique case (ex_word[13:12])
      2'b00: begin
        unique case (ex_word[11:8])
          4'h0: begin
            if (dbit) begin
              wr_en = 1'b1; wr_data = w_reg;
            end else if (f == 7'h00 || f == 7'h20 || f == 7'h40 || f == 7'h60) begin
              nd = 1'b0;
            end else if (f == 7'h08) begin
              sp_n = sp_dn; pc_n = stk_top; cyc = 2'd2;
            end else if (f == 7'h09 || f == 7'h64 || f == 7'h63) begin
              nd = 1'b1;
            end else begin
              bad = 1'b1;
            end
          end
          4'h1: begin
            z_n = 1'b1;
            if (dbit) begin
              wr_en = 1'b1;
            end else begin
              w_n = 8'h00;
            end
          end
          4'h2, 4'h7: begin
            sum = (ex_word[11:8] == 4'h7) ? ({1'b0, fv} + {1'b0, w_reg})
                                          : ({1'b0, fv} - {1'b0, w_reg});
            r    = sum[7:0];
            z_n  = (r == 8'h00);
            if (ex_word[11:8] == 4'h7) begin
              c_n  = sum[8];
              dc_n = ({1'b0, fv[3:0]} + {1'b0, w_reg[3:0]}) > 5'h0F;
            end else begin
              c_n  = fv >= w_reg;
              dc_n = fv[3:0] >= w_reg[3:0];
            end
          end
          4'h3: begin r = fv - 1'b1; z_n = (r == 8'h00); end
          4'h4: begin r = fv | w_reg; z_n = (r == 8'h00); end
          4'h5: begin r = fv & w_reg; z_n = (r == 8'h00); end
          4'h6: begin r = fv ^ w_reg; z_n = (r == 8'h00); end
          4'h8: begin r = fv; z_n = (r == 8'h00); end
          4'h9: begin r = ~fv; z_n = (r == 8'h00); end
          4'hA: begin r = fv + 1'b1; z_n = (r == 8'h00); end
          4'hB, 4'hF: begin
            r = (ex_word[11:8] == 4'hB) ? fv - 1'b1 : fv + 1'b1;
            if (r == 8'h00) begin
              pc_n = pc2; cyc = 2'd2;
            end
          end
          4'hC: begin r = {c_reg, fv[7:1]}; c_n = fv[0]; end
          4'hD: begin r = {fv[6:0], c_reg}; c_n = fv[7]; end
          4'hE: r = {fv[3:0], fv[7:4]};
          default: r = fv;
        endcase
        // Byte ops other than the control group and clear store to W or file.
        if (ex_word[11:9] != 3'b000) begin
          if (dbit) begin
            wr_en = 1'b1; wr_data = r;
          end else begin
            w_n = r;
          end
        end
      end
      2'b01: begin
        unique case (ex_word[11:10])
          2'b00: begin wr_en = 1'b1; wr_data = fv & ~bmask; end
          2'b01: begin wr_en = 1'b1; wr_data = fv | bmask; end
          2'b10: if ((fv & bmask) == 8'h00) begin pc_n = pc2; cyc = 2'd2; end
          default: if ((fv & bmask) != 8'h00) begin pc_n = pc2; cyc = 2'd2; end
        endcase
      end
      2'b10: begin
        push = !ex_word[11];
        if (push) sp_n = (sp == SW'(STACK_DEPTH - 1)) ? '0 : sp + 1'b1;
        pc_n = PC_BITS'(ex_word[10:0]);
        cyc  = 2'd2;
      end
      default: begin
        priority if (ex_word[11:10] == 2'b00) begin
          w_n = k8;
        end else if (ex_word[11:10] == 2'b01) begin
          w_n = k8; sp_n = sp_dn; pc_n = stk_top; cyc = 2'd2;
        end else if (ex_word[11:8] == 4'h8) begin
          w_n = k8 | w_reg; z_n = (w_n == 8'h00);
        end else if (ex_word[11:8] == 4'h9) begin
          w_n = k8 & w_reg; z_n = (w_n == 8'h00);
        end else if (ex_word[11:8] == 4'hA) begin
          w_n = k8 ^ w_reg; z_n = (w_n == 8'h00);
        end else if (ex_word[11:8] == 4'hB) begin
          bad = 1'b1;
        end else if (ex_word[11:9] == 3'b110) begin
          w_n  = k8 - w_reg; z_n = (w_n == 8'h00);
          c_n  = k8 >= w_reg; dc_n = k8[3:0] >= w_reg[3:0];
        end else begin
          sum  = {1'b0, k8} + {1'b0, w_reg};
          w_n  = sum[7:0]; z_n = (w_n == 8'h00); c_n = sum[8];
          dc_n = ({1'b0, k8[3:0]} + {1'b0, w_reg[3:0]}) > 5'h0F;
        end
      end
    endcase
    if (!retire) wr_en = 1'b0;
  end

  // Sequencer and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_busy <= 1'b0; res_valid <= 1'b0;
      w_reg <= '0; c_reg <= 1'b0; dc_reg <= 1'b0; z_reg <= 1'b0;
      pc <= '0; sp <= '0;
    end else begin
      // Result stays up while stalled, or loads when the held word retires.
      res_valid <= retire || (res_valid && res_stall);
      if (take) begin
        ex_busy <= 1'b1;
        ex_word <= in_word;
      end else if (retire) begin
        ex_busy <= 1'b0;
        w_reg <= w_n; c_reg <= c_n; dc_reg <= dc_n; z_reg <= z_n;
        pc <= pc_n; sp <= sp_n;
        res_pc <= pc_n; res_w <= w_n;
        res_status <= '{zero: z_n, dcarry: dc_n, carry: c_n, cycles: cyc,
                        not_done: nd, bad: bad};
      end
    end
  end

  // Return stack written at the push slot.
  always_ff @(posedge clk) begin
    if (retire && push) stack_mem[sp] <= pc1;
  end
endmodule

FILE: rtl/pic_midrange_instruction_execute_unit.sv
// Top level of the mid-range 14-bit instruction execute unit.
// An accepted word is held in the execute register while file RAM is read; its result
// is written back and loads the output register, and only then is the next word taken.
// The output register lets the next word enter while a result waits.
// Reset (rst, synchronous): clears W, flags, PC, stack pointer and handshakes.
// File RAM and return stack hold undefined data until written.
`timescale 1ns / 1ps
module pic_midrange_instruction_execute_unit #(
  parameter int STACK_DEPTH = pic_pkg::StackDepthDef,
  parameter int RAM_WORDS   = pic_pkg::RamWordsDef,
  parameter int PC_BITS     = pic_pkg::PcBitsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [13:0] instr_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [12:0] next_pc,
  output logic [7:0]  w_value,
  output logic        zero_flag,
  output logic        digit_carry,
  output logic        carry_flag,
  output logic [1:0]  cycles_taken,
  output logic        not_done,
  output logic        bad_opcode
);
  import pic_pkg::*;
  logic [PC_BITS-1:0] pc_out;
  pic_status_t        st;

  pic_core #(.STACK_DEPTH(STACK_DEPTH), .RAM_WORDS(RAM_WORDS), .PC_BITS(PC_BITS)) u_core (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_word(instr_word),
    .in_stall(in_stall), .res_valid(out_valid), .res_stall(out_stall),
    .res_pc(pc_out), .res_w(w_value), .res_status(st)
  );

  assign next_pc      = 13'(pc_out);
  assign zero_flag    = st.zero;
  assign digit_carry  = st.dcarry;
  assign carry_flag   = st.carry;
  assign cycles_taken = st.cycles;
  assign not_done     = st.not_done;
  assign bad_opcode   = st.bad;
endmodule

FILE: rtl/pic_checker.sv
// Port checker for the execute unit, bound to the top level.
`timescale 1ns / 1ps
module pic_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] cycles_taken,
  input logic       not_done,
  input logic       bad_opcode
);
  // Results always report cycles_taken as 1 or 2.
  a_cyc: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cycles_taken == 2'd1 || cycles_taken == 2'd2))
    else $error("bad cycle count");
  // Status marks are exclusive.
  a_marks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(not_done && bad_opcode)) else $error("marks overlap");
  // An accepted word makes the unit busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("not busy after accept");
  // Stalled result stays valid.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
endmodule

bind pic_midrange_instruction_execute_unit pic_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .cycles_taken(cycles_taken),
  .not_done(not_done), .bad_opcode(bad_opcode)
);

FILE: dv/tb_pic_midrange_instruction_execute_unit.sv
// Self-checking testbench for the mid-range 14-bit instruction execute unit.
`timescale 1ns / 1ps
module tb_pic_midrange_instruction_execute_unit;
  import pic_pkg::*;

  // Instruction classes, taken from the top two opcode bits
  localparam logic [1:0] CLS_BYTE = 2'd0;
  localparam logic [1:0] CLS_BIT  = 2'd1;
  localparam logic [1:0] CLS_JUMP = 2'd2;
  localparam logic [1:0] CLS_LIT  = 2'd3;

  // Byte-oriented opcodes
  localparam logic [3:0] BYTE_MISC  = 4'h0;
  localparam logic [3:0] BYTE_CLR   = 4'h1;
  localparam logic [3:0] BYTE_SUBWF = 4'h2;
  localparam logic [3:0] BYTE_DECF  = 4'h3;
  localparam logic [3:0] BYTE_IORWF = 4'h4;
  localparam logic [3:0] BYTE_ANDWF = 4'h5;
  localparam logic [3:0] BYTE_XORWF = 4'h6;
  localparam logic [3:0] BYTE_ADDWF = 4'h7;
  localparam logic [3:0] BYTE_MOVF  = 4'h8;
  localparam logic [3:0] BYTE_COMF  = 4'h9;
  localparam logic [3:0] BYTE_INCF  = 4'hA;
  localparam logic [3:0] BYTE_DECFSZ = 4'hB;
  localparam logic [3:0] BYTE_RRF   = 4'hC;
  localparam logic [3:0] BYTE_RLF   = 4'hD;
  localparam logic [3:0] BYTE_INCFSZ = 4'hF;

  // Bit-oriented opcodes
  localparam logic [1:0] BIT_CLR  = 2'd0;
  localparam logic [1:0] BIT_SET  = 2'd1;
  localparam logic [1:0] BIT_TSTC = 2'd2;
  localparam logic [1:0] BIT_TSTS = 2'd3;

  // Miscellaneous file-address codes (byte opcode 0, d = 0)
  localparam logic [6:0] MISC_RETURN = 7'h08;
  localparam logic [6:0] MISC_RETFIE = 7'h09;
  localparam logic [6:0] MISC_SLEEP  = 7'h63;
  localparam logic [6:0] MISC_CLRWDT = 7'h64;

  // Literal opcodes
  localparam logic [3:0] LIT_IORLW = 4'h8;
  localparam logic [3:0] LIT_ANDLW = 4'h9;
  localparam logic [3:0] LIT_XORLW = 4'hA;
  localparam logic [3:0] LIT_BAD   = 4'hB;

  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 3000;

  typedef struct {
    logic [12:0] pc;
    logic [7:0]  w;
    logic        z, dc, c;
    logic [1:0]  cyc;
    logic        nd, bad;
  } exec_result_t;

  logic        clk, rst;
  logic        in_valid, in_stall, out_valid, out_stall;
  logic [13:0] instr_word;
  logic [12:0] next_pc;
  logic [7:0]  w_value;
  logic        zero_flag, digit_carry, carry_flag, not_done, bad_opcode;
  logic [1:0]  cycles_taken;

  // Predicted core state
  logic [7:0]  core_w;
  logic        core_z, core_dc, core_c;
  logic [12:0] core_pc;
  logic [12:0] call_stack [8];
  logic [2:0]  stack_ptr;
  logic [7:0]  file_mem [128];
  bit          mem_written [128];
  bit          stack_written [8];

  exec_result_t pending_results[$];
  int  errors = 0, words_in = 0, words_out = 0, skips_taken = 0, returns_seen = 0;
  bit  calm = 0, hold_req = 0;
  int  idle_cycles = 0;

  pic_midrange_instruction_execute_unit uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .instr_word(instr_word), .out_valid(out_valid), .out_stall(out_stall),
    .next_pc(next_pc), .w_value(w_value), .zero_flag(zero_flag),
    .digit_carry(digit_carry), .carry_flag(carry_flag),
    .cycles_taken(cycles_taken), .not_done(not_done), .bad_opcode(bad_opcode)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Keep words legal: never read file RAM or a stack slot that was never written
  function automatic logic [13:0] legalize(input logic [13:0] w);
    logic reads_mem, is_ret;
    reads_mem = (w[13:12] == CLS_BYTE && w[11:8] >= BYTE_SUBWF) || w[13:12] == CLS_BIT;
    is_ret = (w[13:12] == CLS_BYTE && w[11:7] == 5'd0 && w[6:0] == MISC_RETURN) ||
             (w[13:12] == CLS_LIT && w[11:10] == 2'b01);
    if (reads_mem && !mem_written[w[6:0]])
      return {6'b000000, 1'b1, w[6:0]};
    if (is_ret && !stack_written[stack_ptr - 3'd1])
      return {CLS_JUMP, 1'b0, w[10:0]};
    return w;
  endfunction

  task automatic store_result(input logic dbit, input logic [6:0] f, input logic [7:0] v);
    if (dbit) begin
      file_mem[f] = v;
      mem_written[f] = 1;
    end else begin
      core_w = v;
    end
  endtask

  task automatic do_sub(input logic [7:0] a, input logic dbit, input logic [6:0] f);
    logic [7:0] r;
    r = a - core_w;
    core_c = a >= core_w;
    core_dc = a[3:0] >= core_w[3:0];
    core_z = r == 8'd0;
    store_result(dbit, f, r);
  endtask

  task automatic do_add(input logic [7:0] a, input logic dbit, input logic [6:0] f);
    logic [8:0] s;
    s = a + core_w;
    core_c = s[8];
    core_dc = ({1'b0, a[3:0]} + {1'b0, core_w[3:0]}) > 5'd15;
    core_z = s[7:0] == 8'd0;
    store_result(dbit, f, s[7:0]);
  endtask

  task automatic do_logic(input logic [7:0] r, input logic dbit, input logic [6:0] f);
    core_z = r == 8'd0;
    store_result(dbit, f, r);
  endtask

  // Execute one word on the predicted core and queue the expected result word
  task automatic execute_word(input logic [13:0] w);
    exec_result_t e;
    logic [6:0]  f;
    logic        d;
    logic [7:0]  fv, r, msk;
    logic [12:0] pcn;
    f = w[6:0];
    d = w[7];
    fv = file_mem[f];
    pcn = core_pc + 13'd1;
    e.cyc = 2'd1;
    e.nd = 0;
    e.bad = 0;
    case (w[13:12])
      CLS_BYTE: begin
        case (w[11:8])
          BYTE_MISC: begin
            if (d) store_result(1'b1, f, core_w);
            else if (f[4:0] == 5'd0) begin
            end else if (f == MISC_RETURN) begin
              stack_ptr = stack_ptr - 3'd1;
              pcn = call_stack[stack_ptr];
              e.cyc = 2'd2;
              returns_seen++;
            end else if (f == MISC_RETFIE || f == MISC_SLEEP || f == MISC_CLRWDT) e.nd = 1;
            else e.bad = 1;
          end
          BYTE_CLR: begin
            core_z = 1;
            store_result(d, f, 8'd0);
          end
          BYTE_SUBWF: do_sub(fv, d, f);
          BYTE_DECF:  do_logic(fv - 8'd1, d, f);
          BYTE_IORWF: do_logic(fv | core_w, d, f);
          BYTE_ANDWF: do_logic(fv & core_w, d, f);
          BYTE_XORWF: do_logic(fv ^ core_w, d, f);
          BYTE_ADDWF: do_add(fv, d, f);
          BYTE_MOVF:  do_logic(fv, d, f);
          BYTE_COMF:  do_logic(~fv, d, f);
          BYTE_INCF:  do_logic(fv + 8'd1, d, f);
          BYTE_DECFSZ, BYTE_INCFSZ: begin
            r = (w[11:8] == BYTE_DECFSZ) ? fv - 8'd1 : fv + 8'd1;
            store_result(d, f, r);
            if (r == 8'd0) begin
              pcn = core_pc + 13'd2;
              e.cyc = 2'd2;
              skips_taken++;
            end
          end
          BYTE_RRF: begin
            r = {core_c, fv[7:1]};
            core_c = fv[0];
            store_result(d, f, r);
          end
          BYTE_RLF: begin
            r = {fv[6:0], core_c};
            core_c = fv[7];
            store_result(d, f, r);
          end
          default: store_result(d, f, {fv[3:0], fv[7:4]});
        endcase
      end
      CLS_BIT: begin
        msk = 8'd1 << w[9:7];
        case (w[11:10])
          BIT_CLR: store_result(1'b1, f, fv & ~msk);
          BIT_SET: store_result(1'b1, f, fv | msk);
          default: begin
            if ((w[11:10] == BIT_TSTC && (fv & msk) == 0) ||
                (w[11:10] == BIT_TSTS && (fv & msk) != 0)) begin
              pcn = core_pc + 13'd2;
              e.cyc = 2'd2;
              skips_taken++;
            end
          end
        endcase
      end
      CLS_JUMP: begin
        if (!w[11]) begin
          call_stack[stack_ptr] = pcn;
          stack_written[stack_ptr] = 1;
          stack_ptr = stack_ptr + 3'd1;
        end
        pcn = {2'b00, w[10:0]};
        e.cyc = 2'd2;
      end
      default: begin
        if (w[11:8] < 4'd4) core_w = w[7:0];
        else if (w[11:8] < 4'd8) begin
          core_w = w[7:0];
          stack_ptr = stack_ptr - 3'd1;
          pcn = call_stack[stack_ptr];
          e.cyc = 2'd2;
          returns_seen++;
        end else if (w[11:8] == LIT_IORLW) do_logic(w[7:0] | core_w, 1'b0, 7'd0);
        else if (w[11:8] == LIT_ANDLW) do_logic(w[7:0] & core_w, 1'b0, 7'd0);
        else if (w[11:8] == LIT_XORLW) do_logic(w[7:0] ^ core_w, 1'b0, 7'd0);
        else if (w[11:8] == LIT_BAD) e.bad = 1;
        else if (w[11:8] < 4'hE) do_sub(w[7:0], 1'b0, 7'd0);
        else do_add(w[7:0], 1'b0, 7'd0);
      end
    endcase
    core_pc = pcn;
    e.pc = core_pc;
    e.w = core_w;
    e.z = core_z;
    e.dc = core_dc;
    e.c = core_c;
    pending_results.push_back(e);
  endtask

  // Offer one instruction word and wait for it to be taken
  task automatic send_word(input logic [13:0] raw);
    logic [13:0] w;
    w = legalize(raw);
    in_valid <= 1'b1;
    instr_word <= w;
    do @(posedge clk); while (in_stall);
    execute_word(w);
    words_in++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  function automatic logic [13:0] random_word();
    logic [6:0] misc [5];
    misc = '{7'h00, MISC_RETURN, MISC_RETFIE, MISC_SLEEP, MISC_CLRWDT};
    case ($urandom_range(0, 9))
      0: return {6'b000000, 1'b0, misc[$urandom_range(0, 4)]};
      1: return {6'b000000, 1'b1, 7'($urandom)};
      2: return {CLS_LIT, 4'($urandom_range(0, 3)), 8'($urandom)};
      default: return 14'($urandom);
    endcase
  endfunction

  // Result checking
  always @(posedge clk) begin
    exec_result_t e;
    if (!rst && out_valid && !out_stall) begin
      words_out++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word pc=%0h w=%0h", $time, next_pc, w_value);
      end else begin
        e = pending_results.pop_front();
        if ({next_pc, w_value, zero_flag, digit_carry, carry_flag, cycles_taken,
             not_done, bad_opcode} !== {e.pc, e.w, e.z, e.dc, e.c, e.cyc, e.nd, e.bad}) begin
          errors++;
          $display("%0t: mismatch exp pc=%0h w=%0h z=%0b dc=%0b c=%0b cyc=%0d nd=%0b bad=%0b",
                   $time, e.pc, e.w, e.z, e.dc, e.c, e.cyc, e.nd, e.bad);
          $display("%0t:          got pc=%0h w=%0h z=%0b dc=%0b c=%0b cyc=%0d nd=%0b bad=%0b",
                   $time, next_pc, w_value, zero_flag, digit_carry, carry_flag,
                   cycles_taken, not_done, bad_opcode);
        end
      end
    end
  end

  // Receiver stalls: random bursts, or one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 0;
      end else if (!calm && !rst && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_directed();
    logic [13:0] seq [25];
    seq = '{14'h30FF, 14'h00FF, 14'h077F, 14'h3E01, 14'h3C00, 14'h3000, 14'h3C01,
            14'h0100, 14'h0009, 14'h0063, 14'h0064, 14'h0001, 14'h3B00, 14'h27FF,
            14'h0008, 14'h2FFF, 14'h0DFF, 14'h0CFF, 14'h0EFF, 14'h17FF, 14'h1FFF,
            14'h1BFF, 14'h0BFF, 14'h2000, 14'h3455};
    foreach (seq[i]) send_word(seq[i]);
  endtask

  task automatic test_random_mix(input int n);
    repeat (n) send_word(random_word());
  endtask

  task automatic test_backpressure();
    hold_req = 1;
    while (hold_req) send_word(random_word());
  endtask

  task automatic test_steady(input int n);
    calm = 1;
    repeat (n) send_word(random_word());
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    instr_word = '0;
    core_w = 0; core_z = 0; core_dc = 0; core_c = 0; core_pc = 0; stack_ptr = 0;
    foreach (mem_written[i]) mem_written[i] = 0;
    foreach (stack_written[i]) stack_written[i] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_mix(400);
    test_backpressure();
    test_random_mix(150);
    test_steady(80);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Ran %0d instruction words, %0d results checked; %0d skips, %0d returns.",
             words_in, words_out, skips_taken, returns_seen);
    $display("Covered all opcode classes, stack wrap, long output hold and steady streaming.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
